@@ hdl/cda_pkg.sv @@
// Calendar date adder package: payload structs, op codes, controller states,
// datapath commands and the month-length tables. No dependencies.
package cda_pkg;

    localparam int YEAR_W       = 14;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int AMT_W        = 12;
    localparam int REM_W        = 15;
    localparam int DOY_W        = 9;
    localparam int Q100_W       = 8;

    localparam int MAX_YEAR     = 9999;
    localparam int MAX_AMOUNT   = 4095;
    localparam int YEAR_MONTHS  = 12;
    localparam int WEEK_DAYS    = 7;

    // y / 100 == (y * DIV100_MUL) >> DIV100_SHIFT, exact for any 14-bit year
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = YEAR_W + 13;

    typedef enum logic [1:0] {
        OP_DAYS   = 2'd0,
        OP_WEEKS  = 2'd1,
        OP_MONTHS = 2'd2,
        OP_YEARS  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [AMT_W-1:0]   amount;
    } t_in;

    typedef struct packed {
        logic [YEAR_W-1:0]  result_year;
        logic [MONTH_W-1:0] result_month;
        logic [DAY_W-1:0]   result_day;
        logic               year_overflow;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LMUL,
        ST_LCHK,
        ST_NORM,
        ST_DWALK,
        ST_MWALK,
        ST_YFIX,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_LMUL,
        CMD_LCHK,
        CMD_NORM,
        CMD_DSTEP,
        CMD_MSTEP,
        CMD_YFIX,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       finish;   // current step ends the transaction
        logic       refresh;  // year moved, leap flag must be recomputed
    } t_status;

    function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd2:                      len = 5'd28 + {4'b0, leap};
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // days in the months before month m
    function automatic logic [DOY_W-1:0] days_before(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] base;
        begin
            case (m)
                4'd2:    base = 9'd31;
                4'd3:    base = 9'd59;
                4'd4:    base = 9'd90;
                4'd5:    base = 9'd120;
                4'd6:    base = 9'd151;
                4'd7:    base = 9'd181;
                4'd8:    base = 9'd212;
                4'd9:    base = 9'd243;
                4'd10:   base = 9'd273;
                4'd11:   base = 9'd304;
                4'd12:   base = 9'd334;
                default: base = 9'd0;
            endcase
            return base + {8'b0, leap & (m > 4'd2)};
        end
    endfunction

endpackage

@@ hdl/cda_ctrl.sv @@
// Calendar date adder controller: sequences load, leap-year refresh and
// the day/month/year walks. Depends on cda_pkg.
module cda_ctrl
    import cda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = CMD_NONE;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd   = CMD_LOAD;
                    n_ret   = ST_NORM;
                    n_state = ST_LMUL;
                end
            end
            ST_LMUL: begin
                o_cmd   = CMD_LMUL;
                n_state = ST_LCHK;
            end
            ST_LCHK: begin
                o_cmd   = CMD_LCHK;
                n_state = r_ret;
            end
            ST_NORM: begin
                o_cmd = CMD_NORM;
                if (i_status.finish) begin
                    n_state = ST_DONE;
                end else if (i_status.refresh) begin
                    n_ret   = ST_YFIX;
                    n_state = ST_LMUL;
                end else if (i_status.op == OP_DAYS || i_status.op == OP_WEEKS) begin
                    n_state = ST_DWALK;
                end else begin
                    n_state = ST_MWALK;
                end
            end
            ST_DWALK: begin
                o_cmd = CMD_DSTEP;
                if (i_status.finish) begin
                    n_state = ST_DONE;
                end else if (i_status.refresh) begin
                    n_ret   = ST_DWALK;
                    n_state = ST_LMUL;
                end
            end
            ST_MWALK: begin
                o_cmd = CMD_MSTEP;
                if (i_status.finish) begin
                    n_state = ST_DONE;
                end else if (i_status.refresh) begin
                    n_ret   = ST_MWALK;
                    n_state = ST_LMUL;
                end
            end
            ST_YFIX: begin
                o_cmd   = CMD_YFIX;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd   = CMD_FINISH;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/cda_dpath.sv @@
// Calendar date adder datapath: date registers, leap-year unit (reciprocal
// multiply by 1/100), walk arithmetic and result register. Depends on cda_pkg.
module cda_dpath
    import cda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_in     i_item,
    output t_status o_status,
    output t_out    o_result,
    output logic    o_done
);

    logic [1:0]         r_op, n_op;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [DAY_W-1:0]   r_day, n_day;
    logic [AMT_W-1:0]   r_cnt, n_cnt;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [Q100_W-1:0]  r_q, n_q;
    logic               r_leap, n_leap;
    logic               r_pend, n_pend;
    logic               r_ovf, n_ovf;
    t_out               r_res, n_res;
    logic               r_done, n_done;

    logic [PROD_W-1:0]  prod;
    logic [YEAR_W-1:0]  qx100;
    logic [YEAR_W-1:0]  rem100;
    logic [DAY_W-1:0]   md_cur;
    logic [DAY_W-1:0]   md_next;
    logic [DAY_W-1:0]   feb_len;
    logic [DAY_W-1:0]   day_clamped;
    logic [REM_W-1:0]   year_len;
    logic [REM_W-1:0]   year_inc;
    logic [REM_W-1:0]   year_sum;
    logic [REM_W-1:0]   amt_days;
    logic               inc_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
        r_op    <= n_op;
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_leap  <= n_leap;
        r_pend  <= n_pend;
        r_ovf   <= n_ovf;
        r_res   <= n_res;
    end

    assign prod        = PROD_W'(r_year) * PROD_W'(DIV100_MUL);
    assign qx100       = YEAR_W'(r_q) * YEAR_W'(100);
    assign rem100      = r_year - qx100;
    assign md_cur      = month_days(r_leap, r_month);
    assign md_next     = month_days(r_leap, r_month + 4'd1);
    assign feb_len     = 5'd28 + {4'b0, r_leap};
    assign day_clamped = (r_day > md_cur) ? md_cur : r_day;
    assign year_len    = REM_W'(365) + REM_W'(r_leap);
    assign year_inc    = REM_W'(r_year) + REM_W'(1);
    assign year_sum    = REM_W'(r_year) + REM_W'(r_cnt);
    assign inc_ovf     = year_inc > REM_W'(MAX_YEAR);
    // weeks: amount * 7 as (amount << 3) - amount
    assign amt_days    = (r_op == OP_WEEKS) ? ((REM_W'(r_cnt) << 3) - REM_W'(r_cnt))
                                            : REM_W'(r_cnt);

    always_comb begin
        n_op     = r_op;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_q      = r_q;
        n_leap   = r_leap;
        n_pend   = r_pend;
        n_ovf    = r_ovf;
        n_res    = r_res;
        n_done   = 1'b0;
        o_status = '{op: r_op, finish: 1'b0, refresh: 1'b0};
        case (i_cmd)
            CMD_LOAD: begin
                n_op   = i_item.op;
                n_ovf  = 1'b0;
                n_pend = 1'b0;
                if (i_item.start_year == '0) begin
                    n_year = YEAR_W'(1);
                end else if (i_item.start_year > YEAR_W'(MAX_YEAR)) begin
                    n_year = YEAR_W'(MAX_YEAR);
                end else begin
                    n_year = i_item.start_year;
                end
                if (i_item.start_month == '0) begin
                    n_month = MONTH_W'(1);
                end else if (i_item.start_month > MONTH_W'(YEAR_MONTHS)) begin
                    n_month = MONTH_W'(YEAR_MONTHS);
                end else begin
                    n_month = i_item.start_month;
                end
                n_day = (i_item.start_day == '0) ? DAY_W'(1) : i_item.start_day;
                if (17'(i_item.amount) > 17'(MAX_AMOUNT)) begin
                    n_cnt = AMT_W'(MAX_AMOUNT);
                end else begin
                    n_cnt = i_item.amount;
                end
            end
            CMD_LMUL: begin
                n_q = prod[DIV100_SHIFT +: Q100_W];
            end
            CMD_LCHK: begin
                n_leap = ((r_year[1:0] == 2'b00) && (rem100 != '0)) ||
                         ((rem100 == '0) && (r_q[1:0] == 2'b00));
            end
            CMD_NORM: begin
                n_day = day_clamped;
                case (r_op)
                    OP_DAYS, OP_WEEKS: begin
                        n_rem   = REM_W'(day_clamped) +
                                  REM_W'(days_before(r_leap, r_month)) + amt_days;
                        n_month = MONTH_W'(1);
                    end
                    OP_YEARS: begin
                        if (year_sum > REM_W'(MAX_YEAR)) begin
                            n_ovf           = 1'b1;
                            o_status.finish = 1'b1;
                        end else begin
                            n_year           = year_sum[YEAR_W-1:0];
                            o_status.refresh = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_DSTEP: begin
                if (r_month == MONTH_W'(1) && r_rem > year_len) begin
                    // a whole year fits: skip to January of the next year
                    n_rem = r_rem - year_len;
                    if (inc_ovf) begin
                        n_ovf           = 1'b1;
                        o_status.finish = 1'b1;
                    end else begin
                        n_year           = year_inc[YEAR_W-1:0];
                        o_status.refresh = 1'b1;
                    end
                end else if (r_rem <= REM_W'(md_cur)) begin
                    n_day           = r_rem[DAY_W-1:0];
                    o_status.finish = 1'b1;
                end else begin
                    n_rem = r_rem - REM_W'(md_cur);
                    if (r_month == MONTH_W'(YEAR_MONTHS)) begin
                        n_month = MONTH_W'(1);
                        if (inc_ovf) begin
                            n_ovf           = 1'b1;
                            o_status.finish = 1'b1;
                        end else begin
                            n_year           = year_inc[YEAR_W-1:0];
                            o_status.refresh = 1'b1;
                        end
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end
            end
            CMD_MSTEP: begin
                if (r_pend) begin
                    // February of the year just entered, after leap refresh
                    if (r_day > feb_len) begin
                        n_day = feb_len;
                    end
                    n_pend = 1'b0;
                end else if (r_cnt == '0) begin
                    o_status.finish = 1'b1;
                end else if (r_cnt >= AMT_W'(YEAR_MONTHS)) begin
                    // twelve months at once: the only binding clamp is February
                    n_cnt = r_cnt - AMT_W'(YEAR_MONTHS);
                    if (inc_ovf) begin
                        n_ovf           = 1'b1;
                        o_status.finish = 1'b1;
                    end else begin
                        n_year           = year_inc[YEAR_W-1:0];
                        o_status.refresh = 1'b1;
                        if (r_month == MONTH_W'(1)) begin
                            if (r_day > feb_len) begin
                                n_day = feb_len;
                            end
                        end else begin
                            n_pend = 1'b1;
                        end
                    end
                end else begin
                    n_cnt = r_cnt - AMT_W'(1);
                    if (r_month == MONTH_W'(YEAR_MONTHS)) begin
                        n_month = MONTH_W'(1);
                        if (inc_ovf) begin
                            n_ovf           = 1'b1;
                            o_status.finish = 1'b1;
                        end else begin
                            n_year           = year_inc[YEAR_W-1:0];
                            o_status.refresh = 1'b1;
                        end
                    end else begin
                        n_month = r_month + 4'd1;
                        if (r_day > md_next) begin
                            n_day = md_next;
                        end
                    end
                end
            end
            CMD_YFIX: begin
                if (r_month == MONTH_W'(2) && r_day == DAY_W'(29) && !r_leap) begin
                    n_day = DAY_W'(28);
                end
                o_status.finish = 1'b1;
            end
            CMD_FINISH: begin
                n_done = 1'b1;
                if (r_ovf) begin
                    n_res = '{result_year:  YEAR_W'(MAX_YEAR),
                              result_month: MONTH_W'(YEAR_MONTHS),
                              result_day:   DAY_W'(31),
                              year_overflow: 1'b1};
                end else begin
                    n_res = '{result_year:  r_year,
                              result_month: r_month,
                              result_day:   r_day,
                              year_overflow: 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule

@@ hdl/calendar_date_adder_top.sv @@
// Calendar date adder, top level: controller plus datapath.
// Load, leap refresh (LMUL, LCHK) and normalise, then the walk. Day/week adds: a
// step and a leap refresh per whole year skipped, then up to 12 month steps. Month
// adds: a step and a leap refresh per 12 months, then up to 11 single steps. Year
// adds: refresh and Feb 29 fix. One transaction at a time; busy high until the result.
// Reset is synchronous active low; o_done pulses one cycle, the receiver cannot stall.
module calendar_date_adder_top
    import cda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output t_out o_result,
    output logic o_done
);

    t_cmd    cmd;
    t_status status;

    cda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cda_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_status (status),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

@@ verif/cda_checker.sv @@
// Checker for the calendar date adder: watches the command and result channels,
// predicts each shifted date and compares it field by field. Depends on cda_pkg.
module cda_checker
    import cda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_item,
    input  t_out i_result,
    input  logic i_done,
    output int   o_fail_cnt,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out expected_dates[$];

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_len(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            2:            len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  len = 30;
            default:      len = 31;
        endcase
        return len;
    endfunction

    function automatic t_out shift_date(input t_in it);
        t_out        r;
        t_op         op;
        int unsigned y, m, d, amt, rem, md, k;
        bit          ovf, settled;
        op  = t_op'(it.op);
        y   = 32'(it.start_year);
        m   = 32'(it.start_month);
        d   = 32'(it.start_day);
        amt = 32'(it.amount);
        ovf = 1'b0;
        if (y < 1) y = 1;
        if (y > MAX_YEAR) y = MAX_YEAR;
        if (m < 1) m = 1;
        if (m > YEAR_MONTHS) m = YEAR_MONTHS;
        if (d < 1) d = 1;
        if (d > month_len(y, m)) d = month_len(y, m);
        if (amt > MAX_AMOUNT) amt = MAX_AMOUNT;

        case (op)
            OP_DAYS, OP_WEEKS: begin
                // day of year, then walk month by month from January
                rem = d;
                for (k = 1; k < m; k++) rem += month_len(y, k);
                rem += (op == OP_WEEKS) ? amt * WEEK_DAYS : amt;
                m = 1;
                settled = 1'b0;
                while (!settled) begin
                    md = month_len(y, m);
                    if (rem <= md) begin
                        settled = 1'b1;
                    end else begin
                        rem -= md;
                        m++;
                        if (m > YEAR_MONTHS) begin
                            m = 1;
                            y++;
                            if (y > MAX_YEAR) begin
                                ovf     = 1'b1;
                                settled = 1'b1;
                            end
                        end
                    end
                end
                d = rem;
            end
            OP_MONTHS: begin
                // clamp sticks across later steps
                for (k = 0; k < amt && !ovf; k++) begin
                    m++;
                    if (m > YEAR_MONTHS) begin
                        m = 1;
                        y++;
                        if (y > MAX_YEAR) ovf = 1'b1;
                    end
                    if (!ovf && d > month_len(y, m)) d = month_len(y, m);
                end
            end
            default: begin
                y += amt;
                if (y > MAX_YEAR) ovf = 1'b1;
                else if (m == 2 && d == 29 && !leap_year(y)) d = 28;
            end
        endcase

        if (ovf) begin
            y = MAX_YEAR;
            m = YEAR_MONTHS;
            d = 31;
        end
        r.result_year   = y[YEAR_W-1:0];
        r.result_month  = m[MONTH_W-1:0];
        r.result_day    = d[DAY_W-1:0];
        r.year_overflow = ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (i_rst_n) begin
            // retire before queuing so a stray result can't match a fresh transaction
            if (i_done) begin
                if (expected_dates.size() == 0) begin
                    $error("result with no transaction outstanding: %p", i_result);
                    o_fail_cnt++;
                end else begin
                    want = expected_dates.pop_front();
                    if (i_result.result_year !== want.result_year) begin
                        $error("result_year: expected %0d, actual %0d",
                               want.result_year, i_result.result_year);
                        o_fail_cnt++;
                    end
                    if (i_result.result_month !== want.result_month) begin
                        $error("result_month: expected %0d, actual %0d",
                               want.result_month, i_result.result_month);
                        o_fail_cnt++;
                    end
                    if (i_result.result_day !== want.result_day) begin
                        $error("result_day: expected %0d, actual %0d",
                               want.result_day, i_result.result_day);
                        o_fail_cnt++;
                    end
                    if (i_result.year_overflow !== want.year_overflow) begin
                        $error("year_overflow: expected %0d, actual %0d",
                               want.year_overflow, i_result.year_overflow);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_start && !i_busy) expected_dates.push_back(shift_date(i_item));
            o_pending = expected_dates.size();
        end
    end

endmodule

@@ verif/tb_calendar_date_adder_top.sv @@
// Testbench top for calendar_date_adder_top: clock, reset, directed and random
// commands with random gaps, and the verdict. Depends on cda_pkg and cda_checker.
module tb_calendar_date_adder_top;
    import cda_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1880;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    t_in  item  = '0;
    logic busy;
    t_out result;
    logic done;
    int   fail_cnt;
    int   pending;

    always #6 clk = ~clk;

    calendar_date_adder_top u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item),
        .o_result (result),
        .o_done   (done)
    );

    cda_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (item),
        .i_result   (result),
        .i_done     (done),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    function automatic t_in mk(input t_op op, input int y, input int m, input int d,
                               input int amt);
        t_in it;
        it.op          = op;
        it.start_year  = y[YEAR_W-1:0];
        it.start_month = m[MONTH_W-1:0];
        it.start_day   = d[DAY_W-1:0];
        it.amount      = amt[AMT_W-1:0];
        return it;
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  sel;
        it.op = 2'($urandom_range(3));
        if ($urandom_range(99) < 75) begin
            // well-formed date; year picked to hit overflow and century leap rules
            case ($urandom_range(3))
                0: it.start_year = YEAR_W'($urandom_range(1, MAX_YEAR));
                1: it.start_year = YEAR_W'($urandom_range(MAX_YEAR - 120, MAX_YEAR));
                2: it.start_year = YEAR_W'(100 * $urandom_range(1, 99) - 4 +
                                           $urandom_range(8));
                default: it.start_year = YEAR_W'($urandom_range(1, 400));
            endcase
            it.start_month = MONTH_W'($urandom_range(1, 12));
            it.start_day   = ($urandom_range(9) < 6) ? DAY_W'($urandom_range(1, 28))
                                                     : DAY_W'($urandom_range(29, 31));
        end else begin
            it.start_year  = YEAR_W'($urandom_range(0, 2**YEAR_W - 1));
            it.start_month = MONTH_W'($urandom_range(0, 15));
            it.start_day   = DAY_W'($urandom_range(0, 31));
        end
        sel = $urandom_range(99);
        if (sel < 50)      it.amount = AMT_W'($urandom_range(0, 40));
        else if (sel < 90) it.amount = AMT_W'($urandom_range(0, 2**AMT_W - 1));
        else               it.amount = $urandom_range(1) ? '1 : '0;
        return it;
    endfunction

    // returns at the edge where the transaction is taken; start stays high
    task automatic send_item(input t_in it, input bit allow_idle);
        int gap;
        gap = 0;
        if (allow_idle) begin
            while ($urandom_range(99) < 25) gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial begin
        t_in directed[$];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(mk(OP_DAYS,   9999, 12, 31, 1));     // overflow by one day
        directed.push_back(mk(OP_DAYS,   2024,  2, 28, 1));     // into Feb 29
        directed.push_back(mk(OP_DAYS,   2023,  2, 28, 1));
        directed.push_back(mk(OP_DAYS,      1,  1,  1, 4095));
        directed.push_back(mk(OP_WEEKS,     1,  1,  1, 4095));
        directed.push_back(mk(OP_WEEKS,  9950,  6, 15, 4095));  // weeks past the max year
        directed.push_back(mk(OP_MONTHS, 2023,  1, 31, 2));     // clamp carried to March
        directed.push_back(mk(OP_MONTHS, 2024,  1, 31, 1));
        directed.push_back(mk(OP_MONTHS, 9999,  6, 15, 4095));
        directed.push_back(mk(OP_MONTHS, 2000, 12, 31, 0));
        directed.push_back(mk(OP_MONTHS,    1,  1,  1, 4095));
        directed.push_back(mk(OP_YEARS,  2024,  2, 29, 1));     // leap day repaired
        directed.push_back(mk(OP_YEARS,  2000,  2, 29, 400));
        directed.push_back(mk(OP_YEARS,  1600,  2, 29, 300));   // lands on 1900
        directed.push_back(mk(OP_YEARS,     1,  1,  1, 4095));
        directed.push_back(mk(OP_YEARS,  9999,  1,  1, 1));
        directed.push_back(mk(OP_YEARS,  9999, 12, 31, 0));
        directed.push_back(mk(OP_DAYS,      0,  5, 10, 0));     // year zero
        directed.push_back(mk(OP_YEARS, 16383,  3,  3, 0));     // year above max
        directed.push_back(mk(OP_DAYS,   2010,  0, 15, 3));     // month zero
        directed.push_back(mk(OP_MONTHS, 2010, 15, 31, 1));     // month above 12
        directed.push_back(mk(OP_DAYS,   2010,  7,  0, 0));     // day zero
        directed.push_back(mk(OP_DAYS,   2010,  4, 31, 0));     // day past month end
        directed.push_back(mk(OP_WEEKS,  1900,  2, 30, 0));
        directed.push_back(mk(OP_WEEKS,  2000,  2, 31, 1));

        foreach (directed[i]) send_item(directed[i], 1'b1);
        // middle stretch runs back to back
        for (int n = 0; n < N_RANDOM; n++)
            send_item(random_item(), !(n >= 700 && n < 1000));
        start <= 1'b0;
        // let the checker queue the last transaction before polling
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("calendar_date_adder_top: match");
        end else begin
            $display("calendar_date_adder_top: mismatch");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("calendar_date_adder_top: mismatch");
        $finish;
    end

endmodule
